### rtl/gsa_pkg.sv
// Shared types, widths and constants of the gradient sharpness accumulator.
// Used by the channel interfaces and by every module of the block.
package gsa_pkg;

  localparam int PIX_W   = 8;
  localparam int CFG_W   = 13;
  localparam int IDX_W   = 4;
  localparam int DIAG_W  = 24;
  localparam int GRAD_W  = 27;
  localparam int PEAK_W  = 24;
  localparam int ROW_W   = 40;
  localparam int SCALE_W = 31;
  localparam int SUM_W   = 48;
  localparam int CNT_W   = 24;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_LINE_WIDTH   = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = IDX_W'(1);

  // Reset value of both size registers.
  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(4096);
  localparam logic [CFG_W-1:0] SIZE_MIN   = CFG_W'(3);

  // Diagonal weight 1/sqrt(2) in Q16.
  localparam logic [DIAG_W-1:0] DIAG_Q16 = DIAG_W'(46341);

  // Per-word control that travels down the pipeline.
  typedef struct packed {
    logic valid;
    logic interior;
    logic row_end;
    logic frame_end;
  } gsa_tag_t;

  // Neighbor differences of one window, diagonal ones already weighted.
  typedef struct packed {
    gsa_tag_t                      tag;
    logic [3:0][PIX_W-1:0]         orth;
    logic [3:0][DIAG_W-1:0]        diag;
  } gsa_diff_t;

  // Gradient sum and peak difference of one window.
  typedef struct packed {
    gsa_tag_t            tag;
    logic [GRAD_W-1:0]   grad;
    logic [PEAK_W-1:0]   peak;
  } gsa_grad_t;

  // Frame result word.
  typedef struct packed {
    logic [SUM_W-1:0] weighted_numerator;
    logic [SUM_W-1:0] edge_total;
    logic [SUM_W-1:0] peak_total;
    logic [CNT_W-1:0] interior_pixels;
  } gsa_result_t;

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

### rtl/gsa_if.sv
// Valid/ready channel interfaces of the gradient sharpness accumulator.
// Depends on gsa_pkg for the field widths.
interface gsa_pixel_if;
  logic                       valid;
  logic                       ready;
  logic [gsa_pkg::PIX_W-1:0]  pixel_value;

  modport source(output valid, pixel_value, input ready);
  modport sink(input valid, pixel_value, output ready);
endinterface

interface gsa_result_if;
  logic                       valid;
  logic                       ready;
  logic [gsa_pkg::SUM_W-1:0]  weighted_numerator;
  logic [gsa_pkg::SUM_W-1:0]  edge_total;
  logic [gsa_pkg::SUM_W-1:0]  peak_total;
  logic [gsa_pkg::CNT_W-1:0]  interior_pixels;

  modport source(output valid, weighted_numerator, edge_total, peak_total,
                 interior_pixels, input ready);
  modport sink(input valid, weighted_numerator, edge_total, peak_total,
               interior_pixels, output ready);
endinterface

interface gsa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [gsa_pkg::IDX_W-1:0]  index;
  logic [gsa_pkg::CFG_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/gsa_window.sv
// Raster position counters, the two line stores, the 3x3 window and the
// neighbor difference stage. Depends on gsa_pkg.
module gsa_window #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic                          accept,
  input  logic [gsa_pkg::PIX_W-1:0]     pixel_value,
  input  logic [gsa_pkg::CFG_W-1:0]     width,
  input  logic [gsa_pkg::CFG_W-1:0]     height,
  output logic                          frame_last,
  output gsa_pkg::gsa_diff_t            diff
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic          col_last;
  logic          row_last;

  logic [gsa_pkg::PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [gsa_pkg::PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [gsa_pkg::PIX_W-1:0] up_rd;
  logic [gsa_pkg::PIX_W-1:0] mid_rd;

  gsa_pkg::gsa_tag_t         tag_a;
  logic [gsa_pkg::PIX_W-1:0] px_a;
  logic [XW-1:0]             x_a;

  logic [47:0]               window;
  logic [gsa_pkg::PIX_W-1:0] center;
  logic [3:0][gsa_pkg::PIX_W-1:0] orth_next;
  logic [3:0][gsa_pkg::PIX_W-1:0] diag_raw;

  // Position of the next pixel within the frame.
  assign col_last   = (15'(col) + 15'd1) == {2'b00, width};
  assign row_last   = (15'(row) + 15'd1) == {2'b00, height};
  assign frame_last = col_last && row_last;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        row <= row_last ? '0 : row + YW'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  // Line store reads are registered with the accepted pixel.
  always_ff @(posedge clk) begin
    if (accept) begin
      up_rd  <= upper_mem[col];
      mid_rd <= middle_mem[col];
      px_a   <= pixel_value;
      x_a    <= col;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      tag_a <= '0;
    end else begin
      tag_a.valid     <= accept;
      tag_a.interior  <= (col >= XW'(2)) && (row >= YW'(2));
      tag_a.row_end   <= col_last;
      tag_a.frame_end <= frame_last;
    end
  end

  // Rows move down one line store once the old entry has been read.
  always_ff @(posedge clk) begin
    if (tag_a.valid) begin
      upper_mem[x_a]  <= mid_rd;
      middle_mem[x_a] <= px_a;
    end
  end

  // Window keeps columns x-2 (bytes 0..2) and x-1 (bytes 3..5), top first.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      window <= '0;
    end else if (tag_a.valid) begin
      window <= tag_a.row_end ? '0 : {px_a, mid_rd, up_rd, window[47:24]};
    end
  end

  // Differences between the window center and its eight neighbors.
  assign center = window[39:32];

  always_comb begin
    orth_next[0] = gsa_pkg::abs_diff(center, window[15:8]);
    orth_next[1] = gsa_pkg::abs_diff(center, window[31:24]);
    orth_next[2] = gsa_pkg::abs_diff(center, window[47:40]);
    orth_next[3] = gsa_pkg::abs_diff(center, mid_rd);
    diag_raw[0]  = gsa_pkg::abs_diff(center, window[7:0]);
    diag_raw[1]  = gsa_pkg::abs_diff(center, window[23:16]);
    diag_raw[2]  = gsa_pkg::abs_diff(center, up_rd);
    diag_raw[3]  = gsa_pkg::abs_diff(center, px_a);
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      diff.tag <= '0;
    end else begin
      diff.tag <= tag_a;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      diff.orth[i] <= orth_next[i];
      diff.diag[i] <= gsa_pkg::DIAG_W'(diag_raw[i]) * gsa_pkg::DIAG_Q16;
    end
  end

endmodule

### rtl/gsa_grad.sv
// Sum and maximum of the eight Q16 neighbor differences of one window.
// Depends on gsa_pkg.
module gsa_grad (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  gsa_pkg::gsa_diff_t  diff,
  output gsa_pkg::gsa_grad_t  grad
);

  logic [gsa_pkg::GRAD_W-1:0] sum_next;
  logic [gsa_pkg::PIX_W-1:0]  orth_max;
  logic [gsa_pkg::DIAG_W-1:0] diag_max;
  logic [gsa_pkg::PEAK_W-1:0] orth_q16;

  // Orthogonal terms are the plain difference in Q16.
  always_comb begin
    sum_next = '0;
    orth_max = '0;
    diag_max = '0;
    for (int i = 0; i < 4; i++) begin
      sum_next = sum_next + {3'b000, diff.orth[i], 16'h0000}
               + gsa_pkg::GRAD_W'(diff.diag[i]);
      if (diff.orth[i] > orth_max) begin
        orth_max = diff.orth[i];
      end
      if (diff.diag[i] > diag_max) begin
        diag_max = diff.diag[i];
      end
    end
  end

  assign orth_q16 = {orth_max, 16'h0000};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      grad.tag <= '0;
    end else begin
      grad.tag <= diff.tag;
    end
  end

  always_ff @(posedge clk) begin
    grad.grad <= sum_next;
    grad.peak <= (orth_q16 > diag_max) ? orth_q16 : diag_max;
  end

endmodule

### rtl/gsa_accum.sv
// Row sums, per-row scaling by 100/65536, frame sums and the result register.
// Depends on gsa_pkg.
module gsa_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       restart,
  input  gsa_pkg::gsa_grad_t         grad,
  input  logic [gsa_pkg::CFG_W-1:0]  width,
  input  logic [gsa_pkg::CFG_W-1:0]  height,
  input  logic                       out_ready,
  output logic                       out_valid,
  output gsa_pkg::gsa_result_t       result
);

  localparam int PROD_W = gsa_pkg::ROW_W + 7;

  logic [gsa_pkg::ROW_W-1:0]   row_grad;
  logic [gsa_pkg::ROW_W-1:0]   row_peak;
  logic [gsa_pkg::ROW_W-1:0]   row_grad_next;
  logic [gsa_pkg::ROW_W-1:0]   row_peak_next;
  logic [gsa_pkg::ROW_W-1:0]   fin_grad;
  logic [gsa_pkg::ROW_W-1:0]   fin_peak;
  logic                        fin_valid;
  logic                        fin_frame_end;

  logic [PROD_W-1:0]           prod_grad;
  logic [PROD_W-1:0]           prod_peak;
  logic [gsa_pkg::SCALE_W-1:0] scaled_grad;
  logic [gsa_pkg::SCALE_W-1:0] scaled_peak;
  logic                        scaled_valid;
  logic                        scaled_frame_end;

  logic [gsa_pkg::SUM_W-1:0]   frame_edge;
  logic [gsa_pkg::SUM_W-1:0]   frame_peak;
  logic [gsa_pkg::SUM_W-1:0]   frame_edge_next;
  logic [gsa_pkg::SUM_W-1:0]   frame_peak_next;
  logic [gsa_pkg::SUM_W-1:0]   total_edge;
  logic [gsa_pkg::SUM_W-1:0]   total_peak;
  logic                        total_valid;

  logic [2*gsa_pkg::CFG_W-1:0] count_prod;

  // Row sums; only interior windows contribute.
  always_comb begin
    row_grad_next = row_grad;
    row_peak_next = row_peak;
    if (grad.tag.interior) begin
      row_grad_next = row_grad + gsa_pkg::ROW_W'(grad.grad);
      row_peak_next = row_peak + gsa_pkg::ROW_W'(grad.peak);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row_grad      <= '0;
      row_peak      <= '0;
      fin_valid     <= 1'b0;
      fin_frame_end <= 1'b0;
    end else begin
      fin_valid     <= grad.tag.valid && grad.tag.row_end;
      fin_frame_end <= grad.tag.frame_end;
      if (grad.tag.valid) begin
        row_grad <= grad.tag.row_end ? '0 : row_grad_next;
        row_peak <= grad.tag.row_end ? '0 : row_peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    fin_grad <= row_grad_next;
    fin_peak <= row_peak_next;
  end

  // Scale a finished row: times 100 as 64 + 32 + 4, then drop 16 bits.
  assign prod_grad = {1'b0, fin_grad, 6'd0} + {2'd0, fin_grad, 5'd0}
                   + {5'd0, fin_grad, 2'd0};
  assign prod_peak = {1'b0, fin_peak, 6'd0} + {2'd0, fin_peak, 5'd0}
                   + {5'd0, fin_peak, 2'd0};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      scaled_valid     <= 1'b0;
      scaled_frame_end <= 1'b0;
    end else begin
      scaled_valid     <= fin_valid;
      scaled_frame_end <= fin_frame_end;
    end
  end

  always_ff @(posedge clk) begin
    scaled_grad <= prod_grad[PROD_W-1:16];
    scaled_peak <= prod_peak[PROD_W-1:16];
  end

  // Frame sums; the last row of a frame closes them into the totals.
  assign frame_edge_next = frame_edge + gsa_pkg::SUM_W'(scaled_grad);
  assign frame_peak_next = frame_peak + gsa_pkg::SUM_W'(scaled_peak);

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      frame_edge  <= '0;
      frame_peak  <= '0;
      total_valid <= 1'b0;
    end else begin
      total_valid <= scaled_valid && scaled_frame_end;
      if (scaled_valid) begin
        frame_edge <= scaled_frame_end ? '0 : frame_edge_next;
        frame_peak <= scaled_frame_end ? '0 : frame_peak_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    total_edge <= frame_edge_next;
    total_peak <= frame_peak_next;
  end

  // Result register; the input side keeps it free when a total arrives.
  assign count_prod = (width - gsa_pkg::CFG_W'(2)) * (height - gsa_pkg::CFG_W'(2));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (total_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (total_valid) begin
      result.weighted_numerator <= {total_edge[45:0], 2'b00} + {total_edge[46:0], 1'b0}
                                 + {total_peak[45:0], 2'b00};
      result.edge_total         <= total_edge;
      result.peak_total         <= total_peak;
      result.interior_pixels    <= count_prod[gsa_pkg::CNT_W-1:0];
    end
  end

endmodule

### rtl/gradient_sharpness_accumulator.sv
// Gradient sharpness accumulator: takes one 8-bit grey pixel word per clock in
// raster order and offers one result word per frame with the scaled edge and peak
// sums, 6*edge+4*peak and the interior pixel count. The result word is valid at the
// end of a seven-register pipeline that starts at the edge that accepts the last
// pixel of a frame. The rate is one pixel per cycle, set by the one read and one
// write that each pixel makes in each line store. The input stalls only when the
// last pixel of a frame arrives while the previous result has not been taken. A
// write to the line width or frame height register restarts the frame.
module gradient_sharpness_accumulator #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  gsa_cfg_if.sink     cfg,
  gsa_pixel_if.sink   pixels,
  gsa_result_if.source results
);

  localparam int RESULT_LATENCY = 7;

  logic [gsa_pkg::CFG_W-1:0] line_width;
  logic [gsa_pkg::CFG_W-1:0] frame_height;
  logic [gsa_pkg::CFG_W-1:0] width_eff;
  logic [gsa_pkg::CFG_W-1:0] height_eff;
  logic                      cfg_fire;
  logic                      restart;
  logic                      accept;
  logic                      frame_last;

  gsa_pkg::gsa_diff_t        diff;
  gsa_pkg::gsa_grad_t        grad;
  gsa_pkg::gsa_result_t      result;

  // Configuration registers.
  assign cfg.ready = 1'b1;
  assign cfg_fire  = cfg.valid && cfg.ready;
  assign restart   = cfg_fire && ((cfg.index == gsa_pkg::REG_LINE_WIDTH) ||
                                  (cfg.index == gsa_pkg::REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= gsa_pkg::SIZE_RESET;
      frame_height <= gsa_pkg::SIZE_RESET;
    end else if (cfg_fire) begin
      if (cfg.index == gsa_pkg::REG_LINE_WIDTH) begin
        line_width <= cfg.data;
      end
      if (cfg.index == gsa_pkg::REG_FRAME_HEIGHT) begin
        frame_height <= cfg.data;
      end
    end
  end

  // Sizes saturate to the supported range.
  always_comb begin
    if (line_width < gsa_pkg::SIZE_MIN) begin
      width_eff = gsa_pkg::SIZE_MIN;
    end else if ({2'b00, line_width} > 15'(MAX_WIDTH)) begin
      width_eff = gsa_pkg::CFG_W'(MAX_WIDTH);
    end else begin
      width_eff = line_width;
    end
    if (frame_height < gsa_pkg::SIZE_MIN) begin
      height_eff = gsa_pkg::SIZE_MIN;
    end else if ({2'b00, frame_height} > 15'(MAX_HEIGHT)) begin
      height_eff = gsa_pkg::CFG_W'(MAX_HEIGHT);
    end else begin
      height_eff = frame_height;
    end
  end

  // A frame's last pixel waits only while the previous result is unread.
  assign pixels.ready = !(results.valid && frame_last);
  assign accept       = pixels.valid && pixels.ready;

  gsa_window #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_window (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .accept      (accept),
    .pixel_value (pixels.pixel_value),
    .width       (width_eff),
    .height      (height_eff),
    .frame_last  (frame_last),
    .diff        (diff)
  );

  gsa_grad u_grad (
    .clk     (clk),
    .rst     (rst),
    .restart (restart),
    .diff    (diff),
    .grad    (grad)
  );

  gsa_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .restart   (restart),
    .grad      (grad),
    .width     (width_eff),
    .height    (height_eff),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .result    (result)
  );

  assign results.weighted_numerator = result.weighted_numerator;
  assign results.edge_total         = result.edge_total;
  assign results.peak_total         = result.peak_total;
  assign results.interior_pixels    = result.interior_pixels;

  // A new result follows the last pixel of a frame by a fixed latency.
  assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(accept && frame_last, RESULT_LATENCY))
    else $error("result word not caused by the last pixel of a frame");

  // The numerator is consistent with the two totals it is built from.
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.weighted_numerator ==
      48'(results.edge_total * 48'd6 + results.peak_total * 48'd4))
    else $error("weighted numerator does not match the totals");

  // The interior count follows the active frame size.
  assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.interior_pixels ==
      24'(26'(width_eff - 13'd2) * 26'(height_eff - 13'd2)))
    else $error("interior pixel count does not match the frame size");

endmodule

### tb/gsa_frame_checker.sv
// Checker of the gradient sharpness accumulator: watches the register, pixel and result channels.
// It predicts each frame's result word and compares every result against it.
// Depends on gsa_pkg and the channel interfaces in gsa_if.sv.
module gsa_frame_checker #(
  parameter int MAX_W = 4096,
  parameter int MAX_H = 4096
) (
  input  logic   clk,
  input  logic   rst,
  gsa_cfg_if     cfg,
  gsa_pixel_if   pixels,
  gsa_result_if  results,
  output int     mismatches,
  output int     waiting
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  // Diagonal weight 1/sqrt(2) in Q16, row scale and numerator weights.
  localparam logic [63:0] DIAG_WEIGHT = 64'd46341;
  localparam logic [63:0] ROW_SCALE   = 64'd100;
  localparam logic [63:0] EDGE_WEIGHT = 64'd6;
  localparam logic [63:0] PEAK_WEIGHT = 64'd4;
  localparam int          PRINT_CAP   = 100;

  // Predictor state: two previous rows, the last two window columns, position and sums.
  logic [PIX_W-1:0] upper_row [MAX_W];
  logic [PIX_W-1:0] middle_row [MAX_W];
  logic [47:0]      window_cols;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [ROW_W-1:0] row_grad;
  logic [ROW_W-1:0] row_peak;
  logic [SUM_W-1:0] edge_acc;
  logic [SUM_W-1:0] peak_acc;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;

  // Result words of finished frames, oldest first.
  gsa_result_t frame_results_q [$];

  function automatic int unsigned fit_size(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] pixel_gap(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_CAP) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  task automatic restart_frame();
    window_cols = '0;
    col_pos = 0;
    row_pos = 0;
    row_grad = '0;
    row_peak = '0;
    edge_acc = '0;
    peak_acc = '0;
  endtask

  task automatic apply_write(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    if (idx == REG_LINE_WIDTH) begin
      width_reg = value;
      restart_frame();
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = value;
      restart_frame();
    end
  endtask

  // Advance the window by one pixel; the last pixel of a frame yields a result word.
  task automatic take_pixel(input logic [PIX_W-1:0] p);
    int unsigned      w;
    int unsigned      h;
    int unsigned      x;
    logic [PIX_W-1:0] up;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] c;
    logic [PIX_W-1:0] orth [4];
    logic [PIX_W-1:0] diag [4];
    logic [63:0]      g;
    logic [63:0]      pk;
    logic [63:0]      vo;
    logic [63:0]      vd;
    gsa_result_t      r;
    w = fit_size(width_reg, MAX_W);
    h = fit_size(height_reg, MAX_H);
    x = (col_pos >= w) ? w - 1 : col_pos;
    up = upper_row[x];
    mid = middle_row[x];
    upper_row[x] = mid;
    middle_row[x] = p;

    // Interior pixel: the window center sits in the middle byte of the newer column.
    if (x >= 2 && row_pos >= 2) begin
      c = window_cols[39:32];
      orth[0] = pixel_gap(c, window_cols[15:8]);
      orth[1] = pixel_gap(c, window_cols[31:24]);
      orth[2] = pixel_gap(c, window_cols[47:40]);
      orth[3] = pixel_gap(c, mid);
      diag[0] = pixel_gap(c, window_cols[7:0]);
      diag[1] = pixel_gap(c, window_cols[23:16]);
      diag[2] = pixel_gap(c, up);
      diag[3] = pixel_gap(c, p);
      g = '0;
      pk = '0;
      for (int i = 0; i < 4; i++) begin
        vo = 64'(orth[i]) << 16;
        vd = 64'(diag[i]) * DIAG_WEIGHT;
        g = g + vo + vd;
        if (vo > pk) pk = vo;
        if (vd > pk) pk = vd;
      end
      row_grad = ROW_W'(64'(row_grad) + g);
      row_peak = ROW_W'(64'(row_peak) + pk);
    end
    window_cols = {p, mid, up, window_cols[47:24]};

    if (x + 1 < w) begin
      col_pos = x + 1;
    end else begin
      // Row end: scale the row sums into the frame sums.
      edge_acc = SUM_W'(64'(edge_acc) + ((64'(row_grad) * ROW_SCALE) >> 16));
      peak_acc = SUM_W'(64'(peak_acc) + ((64'(row_peak) * ROW_SCALE) >> 16));
      row_grad = '0;
      row_peak = '0;
      col_pos = 0;
      window_cols = '0;
      if (row_pos + 1 < h) begin
        row_pos = row_pos + 1;
      end else begin
        r.weighted_numerator = SUM_W'(64'(edge_acc) * EDGE_WEIGHT + 64'(peak_acc) * PEAK_WEIGHT);
        r.edge_total = edge_acc;
        r.peak_total = peak_acc;
        r.interior_pixels = CNT_W'((w - 2) * (h - 2));
        frame_results_q = {frame_results_q, r};
        restart_frame();
      end
    end
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s mismatch: got 0x%0h, expected 0x%0h", name, got, want));
    end
  endtask

  task automatic check_result();
    gsa_result_t want;
    if (frame_results_q.size() == 0) begin
      report_mismatch("result word with no frame pending");
    end else begin
      want = frame_results_q.pop_front();
      compare_field("weighted_numerator", results.weighted_numerator, want.weighted_numerator);
      compare_field("edge_total", results.edge_total, want.edge_total);
      compare_field("peak_total", results.peak_total, want.peak_total);
      compare_field("interior_pixels", results.interior_pixels, want.interior_pixels);
    end
  endtask

  // Sample all channels at the clock edge, in the order the block sees them.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_W; i++) begin
        upper_row[i] = '0;
        middle_row[i] = '0;
      end
      width_reg = SIZE_RESET;
      height_reg = SIZE_RESET;
      restart_frame();
      frame_results_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        apply_write(cfg.index, cfg.data);
      end
      if (results.valid && results.ready) begin
        check_result();
      end
      if (pixels.valid && pixels.ready) begin
        take_pixel(pixels.pixel_value);
      end
    end
    waiting <= frame_results_q.size();
  end

endmodule

### tb/gradient_sharpness_accumulator_tb.sv
// Top of the gradient sharpness accumulator testbench: clock, reset, stimulus and verdict.
// Depends on gsa_pkg, the channel interfaces and the gsa_frame_checker module.
module gradient_sharpness_accumulator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  localparam int MAX_W            = 4096;
  localparam int MAX_H            = 4096;
  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int RANDOM_PIXELS    = 650;
  localparam int RANDOM_FRAMES    = 16;
  localparam int PRESSURE_FRAMES  = 10;
  localparam int LARGE_PIXELS     = 48;

  localparam logic [IDX_W-1:0] REG_SPARE_TOP = '1;
  localparam logic [CFG_W-1:0] SIZE_ZERO     = '0;
  localparam logic [CFG_W-1:0] SIZE_ALL_ONES = '1;
  localparam logic [CFG_W-1:0] SIZE_LIMIT    = CFG_W'(MAX_W);

  // A bright dot on black, a dark dot on white, and a frame cut short.
  localparam logic [PIX_W-1:0] BRIGHT_DOT [9] = '{0, 0, 0, 0, 255, 0, 0, 0, 0};
  localparam logic [PIX_W-1:0] DARK_DOT [9] = '{255, 255, 255, 255, 0, 255, 255, 255, 255};
  localparam logic [PIX_W-1:0] CUT_SHORT [4] = '{255, 0, 128, 127};

  typedef enum int {STYLE_UNIFORM, STYLE_SMOOTH, STYLE_EXTREME, STYLE_LEVELS} pixel_style_t;
  typedef enum int {TAKE_ALL, TAKE_HALF, TAKE_FEW} sink_mode_t;

  logic clk;
  logic rst;
  int   mismatches;
  int   waiting;
  int   cycle_count = 0;

  // Sender pacing and the mirror of the frame size the block is using.
  int               burst_left;
  bit               gaps_on;
  bit               hold_armed;
  logic [PIX_W-1:0] last_pixel;
  int unsigned      eff_w;
  int unsigned      eff_h;
  int               random_pixels;
  int               random_frames;

  gsa_cfg_if    cfg_ch ();
  gsa_pixel_if  pix_ch ();
  gsa_result_if res_ch ();

  gradient_sharpness_accumulator u_top (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  gsa_frame_checker #(.MAX_W(MAX_W), .MAX_H(MAX_H)) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_ch),
    .pixels     (pix_ch),
    .results    (res_ch),
    .mismatches (mismatches),
    .waiting    (waiting)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result receiver: stall patterns that change now and then, plus one long hold.
  initial begin
    sink_mode_t mode;
    int         mode_left;
    int         hold_left;
    bit         hold_served;
    res_ch.ready <= 1'b0;
    mode = TAKE_ALL;
    mode_left = 0;
    hold_left = 0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_armed && !hold_served) begin
        hold_served = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(16, 160);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        case (mode)
          TAKE_ALL: begin
            res_ch.ready <= 1'b1;
          end
          TAKE_HALF: begin
            res_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            res_ch.ready <= ($urandom_range(0, 4) == 0);
          end
        endcase
      end
    end
  end

  function automatic int unsigned fit_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < 3) return 3;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input pixel_style_t style);
    int v;
    case (style)
      STYLE_SMOOTH: begin
        v = int'(last_pixel) + int'($urandom_range(0, 8)) - 4;
        v = (v < 0) ? 0 : (v > 255) ? 255 : v;
      end
      STYLE_EXTREME: begin
        v = $urandom_range(0, 1) ? 255 : 0;
      end
      STYLE_LEVELS: begin
        v = 85 * $urandom_range(0, 3);
      end
      default: begin
        v = $urandom_range(0, 255);
      end
    endcase
    last_pixel = PIX_W'(v);
    return last_pixel;
  endfunction

  // Leaves valid high so that back-to-back writes need no second assignment in one step.
  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_LINE_WIDTH) eff_w = fit_dim(value, MAX_W);
    if (idx == REG_FRAME_HEIGHT) eff_h = fit_dim(value, MAX_H);
  endtask

  task automatic close_cfg();
    cfg_ch.valid <= 1'b0;
  endtask

  // One pixel word; a new burst may open with a random gap.
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        pix_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pix_ch.valid <= 1'b1;
    pix_ch.pixel_value <= value;
    do @(posedge clk); while (!pix_ch.ready);
  endtask

  task automatic send_pixels(input pixel_style_t style, input int count);
    repeat (count) send_pixel(pick_pixel(style));
  endtask

  task automatic close_pixels();
    pix_ch.valid <= 1'b0;
  endtask

  // Let the pipeline drain, then wait until every frame result is back.
  task automatic settle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (waiting != 0) @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w_val, input logic [CFG_W-1:0] h_val);
    settle();
    write_reg(REG_LINE_WIDTH, w_val);
    write_reg(REG_FRAME_HEIGHT, h_val);
    close_cfg();
  endtask

  function automatic logic [CFG_W-1:0] pick_width();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return CFG_W'($urandom_range(3, 10));
    if (r < 17) return CFG_W'($urandom_range(0, 2));
    return CFG_W'($urandom_range(11, 24));
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return CFG_W'($urandom_range(3, 6));
    if (r < 17) return CFG_W'($urandom_range(0, 2));
    return CFG_W'($urandom_range(7, 10));
  endfunction

  initial begin
    pixel_style_t     style;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    int               count;
    rst <= 1'b1;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_LINE_WIDTH;
    cfg_ch.data <= SIZE_ZERO;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel_value <= '0;
    burst_left = 0;
    gaps_on = 1'b1;
    hold_armed = 1'b0;
    last_pixel = '0;
    eff_w = MAX_W;
    eff_h = MAX_H;
    random_pixels = 0;
    random_frames = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: sizes below the minimum, dot frames, then a frame cut short by a write.
    write_reg(REG_LINE_WIDTH, SIZE_ZERO);
    write_reg(REG_FRAME_HEIGHT, CFG_W'(2));
    close_cfg();
    for (int i = 0; i < 9; i++) send_pixel(BRIGHT_DOT[i]);
    for (int i = 0; i < 9; i++) send_pixel(DARK_DOT[i]);
    for (int i = 0; i < 4; i++) send_pixel(CUT_SHORT[i]);
    close_pixels();
    settle();
    write_reg(REG_SPARE_TOP, SIZE_ALL_ONES);
    write_reg(REG_LINE_WIDTH, SIZE_MIN);
    close_cfg();

    // Random: mostly whole frames of random content, some cut short.
    while (random_pixels < RANDOM_PIXELS || random_frames < RANDOM_FRAMES) begin
      wv = pick_width();
      hv = pick_height();
      settle();
      if ($urandom_range(0, 1)) begin
        write_reg(REG_LINE_WIDTH, wv);
        write_reg(REG_FRAME_HEIGHT, hv);
      end else begin
        write_reg(REG_FRAME_HEIGHT, hv);
        write_reg(REG_LINE_WIDTH, wv);
      end
      if ($urandom_range(0, 4) == 0) begin
        write_reg(IDX_W'($urandom_range(REG_FRAME_HEIGHT + 1, REG_SPARE_TOP)),
                  CFG_W'($urandom_range(0, 8191)));
      end
      close_cfg();
      gaps_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 3)) begin
        style = pixel_style_t'($urandom_range(0, 3));
        send_pixels(style, eff_w * eff_h);
        random_pixels += eff_w * eff_h;
        random_frames++;
      end
      if ($urandom_range(0, 3) == 0) begin
        count = $urandom_range(1, eff_w * eff_h - 1);
        send_pixels(pixel_style_t'($urandom_range(0, 3)), count);
        random_pixels += count;
      end
      close_pixels();
    end

    // Pressure: small frames back to back while the receiver holds off.
    set_size(SIZE_MIN, SIZE_MIN);
    gaps_on = 1'b0;
    hold_armed = 1'b1;
    repeat (PRESSURE_FRAMES) send_pixels(STYLE_UNIFORM, eff_w * eff_h);
    close_pixels();

    // Largest sizes, each frame cut short: above the limit, at the limit, the tallest.
    gaps_on = 1'b1;
    set_size(SIZE_ALL_ONES, SIZE_ZERO);
    send_pixels(STYLE_SMOOTH, LARGE_PIXELS);
    close_pixels();
    set_size(SIZE_LIMIT, SIZE_MIN);
    send_pixels(STYLE_UNIFORM, LARGE_PIXELS);
    close_pixels();
    set_size(SIZE_MIN, SIZE_ALL_ONES);
    send_pixels(STYLE_LEVELS, LARGE_PIXELS);
    close_pixels();

    // Drain and give the verdict.
    settle();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/gsa_pkg.sv
rtl/gsa_if.sv
rtl/gsa_window.sv
rtl/gsa_grad.sv
rtl/gsa_accum.sv
rtl/gradient_sharpness_accumulator.sv
tb/gsa_frame_checker.sv
tb/gradient_sharpness_accumulator_tb.sv
